// ===== design/pps_pkg.sv =====
// Shared types, register indexes and a helper function for the PES packet splitter.
// Used by pps_out_fifo, pes_packet_splitter_top and the testbench; depends on nothing else.
`default_nettype none

package pps_pkg;

   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 16;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_SELECTED_ID = 2'd0,
      CSR_AUTO_SELECT = 2'd1,
      CSR_MAX_LENGTH  = 2'd2
   } csr_index_type;

   localparam logic [7:0]  PREFIX_END        = 8'h01;
   localparam logic [7:0]  LOWEST_VALID_ID   = 8'hBC;
   localparam logic [7:0]  RESET_SELECTED_ID = 8'hE0;
   localparam logic [15:0] RESET_MAX_LENGTH  = 16'hFFFF;
   localparam logic [2:0]  HEADER_TAIL_BEATS = 3'd5;

   localparam logic [3:0] TYPE_NONE    = 4'd0;
   localparam logic [3:0] TYPE_VIDEO   = 4'd2;
   localparam logic [3:0] TYPE_AUDIO   = 4'd4;
   localparam logic [3:0] TYPE_PRIVATE = 4'd6;
   localparam logic [3:0] TYPE_MHEG    = 4'd7;
   localparam logic [3:0] TYPE_DSMCC   = 4'd8;
   localparam logic [3:0] TYPE_H2221   = 4'd9;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       first_mark;
      logic       last_mark;
      logic [7:0] packet_id;
      logic [3:0] type_guess;
   } rsp_beat_type;

   function automatic logic [3:0] type_of(input logic [7:0] id);
      logic [3:0] t;
      if (id >= 8'hC0 && id <= 8'hDF) begin
         t = TYPE_AUDIO;
      end else if (id >= 8'hE0 && id <= 8'hEF) begin
         t = TYPE_VIDEO;
      end else if (id == 8'hBD || id == 8'hBF) begin
         t = TYPE_PRIVATE;
      end else if (id == 8'hF2) begin
         t = TYPE_DSMCC;
      end else if (id >= 8'hF4 && id <= 8'hF8) begin
         t = TYPE_H2221;
      end else if (id == 8'hF3) begin
         t = TYPE_MHEG;
      end else begin
         t = TYPE_NONE;
      end
      return t;
   endfunction

endpackage

`default_nettype wire

// ===== design/pes_packet_splitter_top.sv =====
// Top level of the PES packet splitter: prefix hunt, header parse, header burst, payload pass.
// Depends on pps_pkg and pps_out_fifo.
//
// Use: raw stream bytes enter on req_* (valid/ready), one per beat. Beats of passed
// packets leave on rsp_* (valid/ready) with first/last marks, stream id and type guess.
// csr_* writes selected_id, auto_select and max_length; write only while idle.
// Results are registered in the result queue and leave on rsp in the order they were made.
// Throughput: one input beat per cycle while req_ready is high. When the last length
// byte of a passed packet is taken, it pushes the first of the six header beats; the
// header sequencer sends the other five, one per cycle while the queue has room, and
// req_ready stays low until they are out. Payload beats then pass at one per cycle
// while req_ready is high. A two-entry result queue sits before rsp, so input is still
// taken while rsp stalls; when the queue is full, req_ready drops until rsp takes a beat.
// Reset: synchronous; clears lock, queue and all parse state but len_low and hdr_last;
// loads selected_id 0xE0, auto_select 0 and max_length 0xFFFF.
`default_nettype none

module pes_packet_splitter_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [7:0]                          req_data_byte,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [7:0]                               rsp_out_byte,
   output logic                                     rsp_first_mark,
   output logic                                     rsp_last_mark,
   output logic [7:0]                               rsp_packet_id,
   output logic [3:0]                               rsp_type_guess,
   input  wire logic                                csr_write,
   input  wire logic [pps_pkg::CsrIndexWidth-1:0]   csr_index,
   input  wire logic [pps_pkg::CsrDataWidth-1:0]    csr_data
);

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_ID,
      PH_LENHI,
      PH_LENLO,
      PH_BODY
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [1:0]  zero_run_ff, zero_run_in;
   logic [7:0]  cur_id_ff, cur_id_in;
   logic [7:0]  len_high_ff, len_high_in;
   logic [7:0]  len_low_ff, len_low_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic        passing_ff, passing_in;
   logic        locked_ff, locked_in;
   logic [7:0]  locked_id_ff, locked_id_in;
   logic [2:0]  hdr_left_ff, hdr_left_in;
   logic        hdr_last_ff, hdr_last_in;

   logic [7:0]  selected_id_ff;
   logic        auto_select_ff;
   logic [15:0] max_length_ff;

   logic        fifo_free;
   logic        req_fire;
   logic        seq_push;
   logic        push_valid;
   pps_pkg::rsp_beat_type push_beat;
   pps_pkg::rsp_beat_type pop_beat;

   logic [7:0]  b;
   logic [15:0] raw_len, clamp_len, body_left;
   logic        lock_now;
   logic [7:0]  active_id;

   assign b         = req_data_byte;
   assign req_ready = (hdr_left_ff == 3'd0) && fifo_free;
   assign req_fire  = req_valid && req_ready;
   assign seq_push  = (hdr_left_ff != 3'd0) && fifo_free;
   assign raw_len   = {len_high_ff, b};
   assign clamp_len = (raw_len > max_length_ff) ? max_length_ff : raw_len;
   assign body_left = bytes_left_ff - 16'd1;
   assign lock_now  = auto_select_ff && !locked_ff;
   assign active_id = lock_now ? b : (locked_ff ? locked_id_ff : selected_id_ff);

   always_comb begin
      phase_in      = phase_ff;
      zero_run_in   = zero_run_ff;
      cur_id_in     = cur_id_ff;
      len_high_in   = len_high_ff;
      len_low_in    = len_low_ff;
      bytes_left_in = bytes_left_ff;
      passing_in    = passing_ff;
      locked_in     = locked_ff;
      locked_id_in  = locked_id_ff;
      hdr_left_in   = hdr_left_ff;
      hdr_last_in   = hdr_last_ff;
      push_valid    = 1'b0;
      push_beat.out_byte   = 8'h00;
      push_beat.first_mark = 1'b0;
      push_beat.last_mark  = 1'b0;
      push_beat.packet_id  = cur_id_ff;
      push_beat.type_guess = pps_pkg::type_of(cur_id_ff);

      if (seq_push) begin
         push_valid  = 1'b1;
         hdr_left_in = hdr_left_ff - 3'd1;
         unique case (hdr_left_ff)
            3'd5:    push_beat.out_byte = 8'h00;
            3'd4:    push_beat.out_byte = pps_pkg::PREFIX_END;
            3'd3:    push_beat.out_byte = cur_id_ff;
            3'd2:    push_beat.out_byte = len_high_ff;
            3'd1: begin
               push_beat.out_byte  = len_low_ff;
               push_beat.last_mark = hdr_last_ff;
            end
            default: push_beat.out_byte = 8'h00;
         endcase
      end else if (req_fire) begin
         unique case (phase_ff)
            PH_ID: begin
               if (b < pps_pkg::LOWEST_VALID_ID) begin
                  phase_in    = PH_HUNT;
                  zero_run_in = (b == 8'h00) ? 2'd1 : 2'd0;
               end else begin
                  cur_id_in  = b;
                  passing_in = (b == active_id);
                  phase_in   = PH_LENHI;
                  if (lock_now) begin
                     locked_in    = 1'b1;
                     locked_id_in = b;
                  end
               end
            end
            PH_LENHI: begin
               len_high_in = b;
               phase_in    = PH_LENLO;
            end
            PH_LENLO: begin
               len_low_in    = b;
               bytes_left_in = clamp_len;
               if (passing_ff) begin
                  push_valid           = 1'b1;
                  push_beat.out_byte   = 8'h00;
                  push_beat.first_mark = 1'b1;
                  hdr_left_in          = pps_pkg::HEADER_TAIL_BEATS;
                  hdr_last_in          = (clamp_len == 16'd0);
               end
               if (clamp_len == 16'd0) begin
                  phase_in    = PH_HUNT;
                  zero_run_in = 2'd0;
               end else begin
                  phase_in = PH_BODY;
               end
            end
            PH_BODY: begin
               bytes_left_in = body_left;
               if (passing_ff) begin
                  push_valid          = 1'b1;
                  push_beat.out_byte  = b;
                  push_beat.last_mark = (body_left == 16'd0);
               end
               if (body_left == 16'd0) begin
                  phase_in    = PH_HUNT;
                  zero_run_in = 2'd0;
               end
            end
            default: begin
               if (b == pps_pkg::PREFIX_END && zero_run_ff[1]) begin
                  phase_in    = PH_ID;
                  zero_run_in = 2'd0;
               end else if (b == 8'h00) begin
                  zero_run_in = zero_run_ff[1] ? 2'd2 : zero_run_ff + 2'd1;
               end else begin
                  zero_run_in = 2'd0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         zero_run_ff   <= 2'd0;
         cur_id_ff     <= 8'h00;
         len_high_ff   <= 8'h00;
         bytes_left_ff <= 16'd0;
         passing_ff    <= 1'b0;
         locked_ff     <= 1'b0;
         locked_id_ff  <= 8'h00;
         hdr_left_ff   <= 3'd0;
      end else begin
         phase_ff      <= phase_in;
         zero_run_ff   <= zero_run_in;
         cur_id_ff     <= cur_id_in;
         len_high_ff   <= len_high_in;
         bytes_left_ff <= bytes_left_in;
         passing_ff    <= passing_in;
         locked_ff     <= locked_in;
         locked_id_ff  <= locked_id_in;
         hdr_left_ff   <= hdr_left_in;
      end
   end

   always_ff @(posedge clock) begin
      len_low_ff  <= len_low_in;
      hdr_last_ff <= hdr_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         selected_id_ff <= pps_pkg::RESET_SELECTED_ID;
         auto_select_ff <= 1'b0;
         max_length_ff  <= pps_pkg::RESET_MAX_LENGTH;
      end else if (csr_write) begin
         unique case (csr_index)
            pps_pkg::CSR_SELECTED_ID: selected_id_ff <= csr_data[7:0];
            pps_pkg::CSR_AUTO_SELECT: auto_select_ff <= csr_data[0];
            pps_pkg::CSR_MAX_LENGTH:  max_length_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   pps_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_beat  (push_beat),
      .push_free  (fifo_free),
      .pop_valid  (rsp_valid),
      .pop_ready  (rsp_ready),
      .pop_beat   (pop_beat)
   );

   assign rsp_out_byte   = pop_beat.out_byte;
   assign rsp_first_mark = pop_beat.first_mark;
   assign rsp_last_mark  = pop_beat.last_mark;
   assign rsp_packet_id  = pop_beat.packet_id;
   assign rsp_type_guess = pop_beat.type_guess;

   a_hdr_start: assert property (@(posedge clock) disable iff (reset)
      (req_fire && phase_ff == PH_LENLO && passing_ff)
         |=> (hdr_left_ff == pps_pkg::HEADER_TAIL_BEATS))
      else $error("header burst not started after length");

   a_hdr_step: assert property (@(posedge clock) disable iff (reset)
      seq_push |=> (hdr_left_ff == $past(hdr_left_ff) - 3'd1))
      else $error("header sequencer skipped a beat");

   a_body_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BODY) |-> (bytes_left_ff != 16'd0))
      else $error("payload phase with no bytes left");

   a_lock_hold: assert property (@(posedge clock) disable iff (reset)
      locked_ff |=> (locked_ff && $stable(locked_id_ff)))
      else $error("stream lock changed after it was taken");

endmodule

`default_nettype wire

// ===== design/pps_out_fifo.sv =====
// Two-entry result queue between the packet parser and the rsp channel.
// Depends on pps_pkg for the result beat type.
`default_nettype none

module pps_out_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   input  wire pps_pkg::rsp_beat_type push_beat,
   output logic                      push_free,
   output logic                      pop_valid,
   input  wire logic                 pop_ready,
   output pps_pkg::rsp_beat_type     pop_beat
);

   pps_pkg::rsp_beat_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_free = (count_ff != 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_beat  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && push_free;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_beat;
      end
   end

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for pes_packet_splitter_top: directed byte script, then random PES
// streams under several register settings, all results checked beat by beat.
// Depends on pps_pkg and the design sources only.

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pps_pkg::*;

   typedef enum logic [2:0] {
      HUNT_PREFIX,
      TAKE_ID,
      TAKE_LEN_HI,
      TAKE_LEN_LO,
      TAKE_PAYLOAD
   } parse_state_type;

   typedef enum logic [1:0] {
      EXP_PREDICTED,
      EXP_NONE,
      EXP_PAYLOAD
   } exp_kind_type;

   typedef struct packed {
      logic [7:0]   data;
      exp_kind_type kind;
      logic         tail_mark;
   } script_row_type;

   localparam logic [CsrIndexWidth-1:0] CSR_SPARE = 2'd3;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [7:0]               req_data_byte = 8'h00;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [7:0]               rsp_out_byte;
   logic                     rsp_first_mark;
   logic                     rsp_last_mark;
   logic [7:0]               rsp_packet_id;
   logic [3:0]               rsp_type_guess;
   logic                     csr_write = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_data = '0;

   pes_packet_splitter_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_first_mark (rsp_first_mark),
      .rsp_last_mark  (rsp_last_mark),
      .rsp_packet_id  (rsp_packet_id),
      .rsp_type_guess (rsp_type_guess),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   // splitter mirror: registers
   logic [7:0]      want_id = RESET_SELECTED_ID;
   logic            auto_lock = 1'b0;
   logic [15:0]     len_cap = RESET_MAX_LENGTH;
   // splitter mirror: parse state
   logic [1:0]      zeros_seen = 2'd0;
   parse_state_type parse_at = HUNT_PREFIX;
   logic [7:0]      pkt_id = 8'h00;
   logic [7:0]      len_msb = 8'h00;
   logic [15:0]     payload_left = 16'h0000;
   logic            pass_pkt = 1'b0;
   logic            id_locked = 1'b0;
   logic [7:0]      lock_value = 8'h00;

   rsp_beat_type    burst [6];
   rsp_beat_type    pes_beats_due [$];
   rsp_beat_type    due;
   int unsigned     bytes_sent = 0;
   int unsigned     mismatches = 0;
   int unsigned     pace = 0;

   script_row_type  script [25] = '{
      '{8'h00, EXP_NONE, 1'b0}, '{8'h00, EXP_NONE, 1'b0}, '{8'h00, EXP_NONE, 1'b0},
      '{8'h01, EXP_NONE, 1'b0}, '{8'hE0, EXP_NONE, 1'b0}, '{8'h00, EXP_NONE, 1'b0},
      '{8'h02, EXP_PREDICTED, 1'b0},
      '{8'hFF, EXP_PAYLOAD, 1'b0}, '{8'h00, EXP_PAYLOAD, 1'b1},
      '{8'h00, EXP_NONE, 1'b0}, '{8'h00, EXP_NONE, 1'b0}, '{8'h01, EXP_NONE, 1'b0},
      '{8'h00, EXP_NONE, 1'b0}, '{8'h00, EXP_NONE, 1'b0}, '{8'h01, EXP_NONE, 1'b0},
      '{8'hBD, EXP_NONE, 1'b0}, '{8'h00, EXP_NONE, 1'b0}, '{8'h01, EXP_NONE, 1'b0},
      '{8'hAA, EXP_NONE, 1'b0},
      '{8'h00, EXP_NONE, 1'b0}, '{8'h00, EXP_NONE, 1'b0}, '{8'h01, EXP_NONE, 1'b0},
      '{8'hE0, EXP_NONE, 1'b0}, '{8'h00, EXP_NONE, 1'b0},
      '{8'h00, EXP_PREDICTED, 1'b0}
   };

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("tb: FAIL");
      $finish;
   end

   function automatic logic [3:0] stream_kind(input logic [7:0] id);
      if (id >= 8'hE0 && id <= 8'hEF) return TYPE_VIDEO;
      if (id[7:5] == 3'b110) return TYPE_AUDIO;
      if (id == 8'hBD || id == 8'hBF) return TYPE_PRIVATE;
      if (id == 8'hF3) return TYPE_MHEG;
      if (id == 8'hF2) return TYPE_DSMCC;
      if (id >= 8'hF4 && id <= 8'hF8) return TYPE_H2221;
      return TYPE_NONE;
   endfunction

   function automatic rsp_beat_type pes_beat(input logic [7:0] b, input logic head_mark,
                                             input logic tail_mark);
      rsp_beat_type r;
      r.out_byte   = b;
      r.first_mark = head_mark;
      r.last_mark  = tail_mark;
      r.packet_id  = pkt_id;
      r.type_guess = stream_kind(pkt_id);
      return r;
   endfunction

   function automatic logic [7:0] active_id();
      return id_locked ? lock_value : want_id;
   endfunction

   // advance the mirror by one stream byte; fills burst, returns beat count
   function automatic int demux_byte(input logic [7:0] b);
      int          n;
      logic [15:0] span;
      n = 0;
      case (parse_at)
         TAKE_ID: begin
            if (b < LOWEST_VALID_ID) begin
               parse_at   = HUNT_PREFIX;
               zeros_seen = (b == 8'h00) ? 2'd1 : 2'd0;
            end else begin
               pkt_id = b;
               if (auto_lock && !id_locked) begin
                  id_locked  = 1'b1;
                  lock_value = b;
               end
               pass_pkt = (b == active_id());
               parse_at = TAKE_LEN_HI;
            end
         end
         TAKE_LEN_HI: begin
            len_msb  = b;
            parse_at = TAKE_LEN_LO;
         end
         TAKE_LEN_LO: begin
            span = {len_msb, b};
            if (span > len_cap) span = len_cap;
            payload_left = span;
            if (pass_pkt) begin
               burst[0] = pes_beat(8'h00, 1'b1, 1'b0);
               burst[1] = pes_beat(8'h00, 1'b0, 1'b0);
               burst[2] = pes_beat(PREFIX_END, 1'b0, 1'b0);
               burst[3] = pes_beat(pkt_id, 1'b0, 1'b0);
               burst[4] = pes_beat(len_msb, 1'b0, 1'b0);
               burst[5] = pes_beat(b, 1'b0, span == 16'h0000);
               n = 6;
            end
            zeros_seen = 2'd0;
            parse_at   = (span == 16'h0000) ? HUNT_PREFIX : TAKE_PAYLOAD;
         end
         TAKE_PAYLOAD: begin
            payload_left = payload_left - 16'd1;
            if (pass_pkt) begin
               burst[0] = pes_beat(b, 1'b0, payload_left == 16'h0000);
               n = 1;
            end
            if (payload_left == 16'h0000) begin
               parse_at   = HUNT_PREFIX;
               zeros_seen = 2'd0;
            end
         end
         default: begin
            if (b == PREFIX_END && zeros_seen >= 2'd2) begin
               parse_at   = TAKE_ID;
               zeros_seen = 2'd0;
            end else if (b == 8'h00) begin
               if (zeros_seen < 2'd2) zeros_seen = zeros_seen + 2'd1;
            end else begin
               zeros_seen = 2'd0;
            end
         end
      endcase
      return n;
   endfunction

   // call at a falling edge; returns at a falling edge with valid still high unless idling
   task automatic send_byte(input logic [7:0] b, input exp_kind_type kind,
                            input logic tail_mark);
      int n;
      req_valid     <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (!req_ready);
      n = demux_byte(b);
      if (kind == EXP_PREDICTED) begin
         for (int i = 0; i < n; i++) pes_beats_due.push_back(burst[i]);
      end else if (kind == EXP_PAYLOAD) begin
         pes_beats_due.push_back('{b, 1'b0, tail_mark, 8'hE0, TYPE_VIDEO});
      end
      bytes_sent++;
      @(negedge clock);
      if (pace != 0 && $urandom_range(1, pace) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
   endtask

   task automatic write_reg(input logic [CsrIndexWidth-1:0] idx, input logic [15:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      case (idx)
         CSR_SELECTED_ID: want_id = value[7:0];
         CSR_AUTO_SELECT: auto_lock = value[0];
         CSR_MAX_LENGTH:  len_cap = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // finish any open packet, then drain and let the header sequencer go quiet
   task automatic settle();
      while (parse_at != HUNT_PREFIX) send_byte(8'h00, EXP_PREDICTED, 1'b0);
      req_valid <= 1'b0;
      while (pes_beats_due.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic send_packet();
      int unsigned pick;
      int unsigned body;
      logic [7:0]  id;
      logic [15:0] span;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         repeat ($urandom_range(1, 4))
            send_byte(8'($urandom_range(0, 255)), EXP_PREDICTED, 1'b0);
         return;
      end
      repeat (($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 4))
         send_byte(8'h00, EXP_PREDICTED, 1'b0);
      send_byte(PREFIX_END, EXP_PREDICTED, 1'b0);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         if (id_locked) id = lock_value;
         else if (auto_lock || want_id < LOWEST_VALID_ID) id = 8'($urandom_range(8'hBC, 8'hFF));
         else id = want_id;
      end else if (pick < 90) begin
         id = 8'($urandom_range(8'hBC, 8'hFF));
      end else begin
         id = 8'($urandom_range(8'h00, 8'hBB));
      end
      send_byte(id, EXP_PREDICTED, 1'b0);
      if (id < LOWEST_VALID_ID) return;
      pick = $urandom_range(0, 99);
      if (pick < 70) span = 16'($urandom_range(0, 12));
      else if (pick < 97) span = (len_cap < 16'd64) ? 16'($urandom_range(0, 65535))
                                                    : 16'($urandom_range(13, 40));
      else span = 16'($urandom_range(256, 300));
      send_byte(span[15:8], EXP_PREDICTED, 1'b0);
      send_byte(span[7:0], EXP_PREDICTED, 1'b0);
      body = 32'((span > len_cap) ? len_cap : span);
      // cut the payload short now and then
      if (body > 1 && $urandom_range(0, 19) == 0) body = $urandom_range(0, body - 1);
      repeat (body) send_byte(8'($urandom_range(0, 255)), EXP_PREDICTED, 1'b0);
   endtask

   task automatic run_phase(input logic [7:0] id, input logic auto_on, input logic [15:0] cap,
                            input int unsigned budget, input bit calm_run);
      logic [7:0]  junk;
      int unsigned goal;
      junk = 8'($urandom_range(0, 255));
      write_reg(CSR_SELECTED_ID, {junk, id});
      write_reg(CSR_AUTO_SELECT, {junk, junk[6:0], auto_on});
      write_reg(CSR_MAX_LENGTH, cap);
      write_reg(CSR_SPARE, {junk, ~junk});
      csr_write <= 1'b0;
      if (calm_run || $urandom_range(0, 3) == 0) pace = 0;
      else pace = $urandom_range(3, 8);
      goal = bytes_sent + budget;
      while (bytes_sent < goal) send_packet();
      settle();
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      pace = 4;
      for (int k = 0; k < 25; k++) send_byte(script[k].data, script[k].kind, script[k].tail_mark);
      settle();
      run_phase(8'hC3, 1'b0, 16'hFFFF, 45, 1'b0);
      run_phase(8'hFF, 1'b0, 16'h0000, 35, 1'b0);
      run_phase(8'h00, 1'b0, 16'h0003, 20, 1'b0);
      run_phase(8'hBD, 1'b0, 16'($urandom_range(1, 20)), 40, 1'b0);
      run_phase(8'($urandom_range(0, 255)), 1'b1, 16'hFFFF, 40, 1'b0);
      run_phase(8'hE0, 1'b0, 16'h000A, 40, 1'b0);
      run_phase(8'($urandom_range(0, 255)), 1'b1, 16'($urandom_range(0, 40)), 40, 1'b1);
      repeat (12) @(posedge clock);
      if (mismatches == 0 && pes_beats_due.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   initial begin
      forever begin
         @(negedge clock);
         if (pace != 0 && $urandom_range(1, pace) == 1) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pes_beats_due.size() == 0) begin
            $error("unexpected beat: out_byte %02h packet_id %02h", rsp_out_byte, rsp_packet_id);
            mismatches++;
         end else begin
            due = pes_beats_due.pop_front();
            if (rsp_out_byte !== due.out_byte) begin
               $error("out_byte: expected %02h, got %02h", due.out_byte, rsp_out_byte);
               mismatches++;
            end
            if (rsp_first_mark !== due.first_mark) begin
               $error("first_mark: expected %0b, got %0b", due.first_mark, rsp_first_mark);
               mismatches++;
            end
            if (rsp_last_mark !== due.last_mark) begin
               $error("last_mark: expected %0b, got %0b", due.last_mark, rsp_last_mark);
               mismatches++;
            end
            if (rsp_packet_id !== due.packet_id) begin
               $error("packet_id: expected %02h, got %02h", due.packet_id, rsp_packet_id);
               mismatches++;
            end
            if (rsp_type_guess !== due.type_guess) begin
               $error("type_guess: expected %0d, got %0d", due.type_guess, rsp_type_guess);
               mismatches++;
            end
         end
      end
   end

endmodule
